### hw/rtl/ncd_pkg.sv
`default_nettype none

package ncd_pkg;

   // Stream geometry: one word of samples plus up to nine carried bits.
   localparam int WordBits   = 32;
   localparam int CharBits   = 10;
   localparam int CarryBits  = CharBits - 1;
   localparam int StreamBits = WordBits + CarryBits;
   localparam int CountBits  = $clog2(StreamBits + 1);
   localparam int CarryCntW  = $clog2(CharBits);

   // Character status codes.
   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusBadStart = 2'd1;
   localparam logic [1:0] StatusBadStop  = 2'd2;

   // Decoded character as seen by the sequencer.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
   } char_type;

endpackage

`default_nettype wire

### hw/rtl/ncd_char_decode.sv
`default_nettype none

module ncd_char_decode (
   input  wire  logic [ncd_pkg::CharBits-1:0] raw_char,
   output       ncd_pkg::char_type             decoded
);
   import ncd_pkg::*;

   // The start bit is checked before the stop bit.
   always_comb begin
      decoded.data_byte = raw_char[8:1];
      if (!raw_char[0]) begin
         decoded.status = StatusBadStart;
      end else if (raw_char[CharBits-1]) begin
         decoded.status = StatusBadStop;
      end else begin
         decoded.status = StatusOk;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/nrzl_character_deframer.sv
// NRZ-L character deframer.
// The req channel carries one word of 32 line samples per transaction, the
// earliest sample in bit 0; req_tuser high marks the start of a frame and
// drops any bits carried over from the previous word. The samples are
// appended to the carried bits and cut into 10-bit characters, LSB first.
// Each character leaves on the rsp channel as one transaction: the data
// byte (character bits 1..8) and a status (ok, bad start, bad stop), with
// rsp_tlast on the final character taken from the word.
// Operation: a word is loaded into the shift register behind the carried
// bits; the shift register then moves ten bits per cycle into the output
// register whenever that register is free: three characters per word, or
// four when eight or nine bits were carried. The first character reaches
// the output register from the shift register. req_tready is low while characters are being cut.
// When the receiver stalls, the output register holds its character and
// the shift register waits; the next word can be accepted while the last
// character of the previous one is still waiting to be taken.
// Reset clears the carried bits, the sequencer and the output valid.
`default_nettype none

module nrzl_character_deframer (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output       logic        req_tready,
   input  wire  logic [31:0] req_tdata,   // [31:0] sample_word
   input  wire  logic        req_tuser,   // [0] frame_start
   output       logic        rsp_tvalid,
   input  wire  logic        rsp_tready,
   output       logic [15:0] rsp_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
   output       logic        rsp_tlast
);
   import ncd_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   logic                  state_ff, state_in;
   logic [StreamBits-1:0] stream_ff, stream_in;
   logic [CountBits-1:0]  bits_ff, bits_in;
   logic [CarryBits-1:0]  carry_bits_ff, carry_bits_in;
   logic [CarryCntW-1:0]  carry_cnt_ff, carry_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   char_type              rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   char_type              decoded;
   logic                  take_word;
   logic                  load_out;
   logic [CountBits-1:0]  bits_left;
   logic [StreamBits-1:0] stream_next;
   logic [CarryCntW-1:0]  cnt_eff;
   logic [CarryBits-1:0]  carry_eff;

   ncd_char_decode u_decode (
      .raw_char (stream_ff[CharBits-1:0]),
      .decoded  (decoded)
   );

   assign take_word   = req_tvalid && req_tready;
   assign load_out    = (state_ff == StRun) && (!rsp_valid_ff || rsp_tready);
   assign bits_left   = bits_ff - CountBits'(CharBits);
   assign stream_next = stream_ff >> CharBits;
   assign cnt_eff     = req_tuser ? '0 : carry_cnt_ff;
   assign carry_eff   = req_tuser ? '0 : carry_bits_ff;

   // Sequencer: load a word behind the carried bits, then peel off one
   // character per cycle whenever the output register is free.
   always_comb begin
      state_in      = state_ff;
      stream_in     = stream_ff;
      bits_in       = bits_ff;
      carry_bits_in = carry_bits_ff;
      carry_cnt_in  = carry_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         StIdle: begin
            if (take_word) begin
               stream_in = (StreamBits'(req_tdata[WordBits-1:0]) << cnt_eff)
                           | StreamBits'(carry_eff);
               bits_in   = CountBits'(cnt_eff) + CountBits'(WordBits);
               state_in  = StRun;
            end
         end
         StRun: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = decoded;
               rsp_last_in  = bits_left < CountBits'(CharBits);
               stream_in    = stream_next;
               bits_in      = bits_left;
               if (bits_left < CountBits'(CharBits)) begin
                  carry_bits_in = stream_next[CarryBits-1:0];
                  carry_cnt_in  = bits_left[CarryCntW-1:0];
                  state_in      = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Control state is reset; the stream and output payload are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         bits_ff       <= '0;
         carry_bits_ff <= '0;
         carry_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bits_ff       <= bits_in;
         carry_bits_ff <= carry_bits_in;
         carry_cnt_ff  <= carry_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stream_ff   <= stream_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_char_ff.status, rsp_char_ff.data_byte};
   assign rsp_tlast  = rsp_last_ff;

   // The carry never holds a whole character.
   a_carry_short: assert property (@(posedge clock) disable iff (reset)
      carry_cnt_ff < CarryCntW'(CharBits))
      else $error("carry count reached a full character");

   // While cutting, at least one full character remains in the stream.
   a_run_has_char: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRun) |-> (bits_ff >= CountBits'(CharBits)))
      else $error("sequencer running without a full character");

   // An accepted word always starts the cutting sequence.
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == StRun))
      else $error("accepted word did not start the sequencer");

   // The status field never carries an unused code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:8] == StatusOk || rsp_tdata[9:8] == StatusBadStart
                      || rsp_tdata[9:8] == StatusBadStop))
      else $error("undefined status code on output");

endmodule

`default_nettype wire

### tb/tb_nrzl_character_deframer.sv
`default_nettype none

module tb_nrzl_character_deframer;

   localparam int CycleLimit = 400000;
   localparam int RandomWords = 230;

   // Expected character with its end-of-word marker.
   typedef struct {
      ncd_pkg::char_type ch;
      logic              last;
   } char_expect_type;

   // Predicts the characters cut from each accepted word and checks them in order.
   class char_scoreboard;
      logic [ncd_pkg::CarryBits-1:0] carry_bits;
      int                            carry_count;
      char_expect_type               expected_q[$];
      int                            errors;

      function new();
         carry_bits  = '0;
         carry_count = 0;
         errors      = 0;
      endfunction

      task report(input string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      function int pending();
         return expected_q.size();
      endfunction

      // Appends the word after the carried bits and cuts 10-bit characters.
      function void note_word(input logic [ncd_pkg::WordBits-1:0] word,
                              input logic frame_start);
         logic [ncd_pkg::StreamBits-1:0] stream;
         logic [ncd_pkg::StreamBits-1:0] carry_mask;
         logic [ncd_pkg::CharBits-1:0]   ch;
         char_expect_type                e;
         int                             cnt;
         int                             total;
         int                             full;
         int                             emit;
         cnt = frame_start ? 0 : carry_count;
         carry_mask = (ncd_pkg::StreamBits'(1) << cnt) - 1'b1;
         stream = (ncd_pkg::StreamBits'(word) << cnt)
                  | (ncd_pkg::StreamBits'(carry_bits) & carry_mask);
         total = cnt + ncd_pkg::WordBits;
         full  = total / ncd_pkg::CharBits;
         emit  = (full > 4) ? 4 : full;
         for (int k = 0; k < emit; k++) begin
            ch = stream[k*ncd_pkg::CharBits +: ncd_pkg::CharBits];
            // A bad start bit wins over a bad stop bit.
            if (!ch[0]) begin
               e.ch.status = ncd_pkg::StatusBadStart;
            end else if (ch[ncd_pkg::CharBits-1]) begin
               e.ch.status = ncd_pkg::StatusBadStop;
            end else begin
               e.ch.status = ncd_pkg::StatusOk;
            end
            e.ch.data_byte = ch[8:1];
            e.last         = (k == emit - 1);
            expected_q.push_back(e);
         end
         // Bits above the stream length are zero, so a plain shift gives the carry.
         carry_bits  = ncd_pkg::CarryBits'(stream >> (full * ncd_pkg::CharBits));
         carry_count = total - full * ncd_pkg::CharBits;
      endfunction

      task check_char(input logic [15:0] tdata, input logic tlast);
         char_expect_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected character tdata=%h", tdata));
         end else begin
            e = expected_q.pop_front();
            if (tdata[7:0] !== e.ch.data_byte)
               report($sformatf("data_byte %h, expected %h", tdata[7:0], e.ch.data_byte));
            if (tdata[9:8] !== e.ch.status)
               report($sformatf("status %0d, expected %0d", tdata[9:8], e.ch.status));
            if (tdata[15:10] !== 6'd0)
               report($sformatf("padding bits %h not zero", tdata[15:10]));
            if (tlast !== e.last)
               report($sformatf("last %b, expected %b", tlast, e.last));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] sample_word
   logic        req_tuser = 1'b0; // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] data_byte, [9:8] status, [15:10] zero
   logic        rsp_tlast;

   char_scoreboard sb = new();
   int             items_sent = 0;
   int             cycle_count = 0;
   int             rsp_stall_left = 0;
   bit             quiet = 1'b0;

   nrzl_character_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none, some short, a few long; none in quiet stretches.
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Builds a 10-bit line character from its start bit, byte and stop bit.
   function automatic logic [9:0] make_char(input logic [7:0] data_byte,
                                            input logic start_bit, input logic stop_bit);
      return {stop_bit, data_byte, start_bit};
   endfunction

   // Watches both channels at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_char(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_word(req_tdata, req_tuser);
      end
   end

   // Receiver with random stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall_left = pick_gap();
         end
      end
   end

   // Offers one word and waits until the transaction completes.
   task automatic send_word(input logic [31:0] word, input logic frame_start);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Stops offering words until every expected character has arrived.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Sends a frame of characters packed back to back; some framing bits get flipped.
   task automatic send_frame(input int nchars, input int corrupt_pct, input bit frame_start);
      logic [63:0] bits;
      logic [63:0] fill_mask;
      logic [9:0]  ch;
      int          nbits;
      bit          first;
      bits  = '0;
      nbits = 0;
      first = 1'b1;
      for (int i = 0; i < nchars; i++) begin
         ch = make_char(8'($urandom), 1'b1, 1'b0);
         if ($urandom_range(0, 99) < corrupt_pct) begin
            case ($urandom_range(0, 2))
               0: ch[0] = 1'b0;
               1: ch[9] = 1'b1;
               default: begin
                  ch[0] = 1'b0;
                  ch[9] = 1'b1;
               end
            endcase
         end
         bits  = bits | (64'(ch) << nbits);
         nbits = nbits + 10;
         if (nbits >= 32) begin
            send_word(bits[31:0], first ? frame_start : 1'b0);
            first = 1'b0;
            bits  = bits >> 32;
            nbits = nbits - 32;
         end
      end
      // Fill the tail of the last word with random line noise.
      if (nbits > 0) begin
         fill_mask = (64'd1 << nbits) - 1;
         send_word(bits[31:0] | ($urandom & ~fill_mask[31:0]), first ? frame_start : 1'b0);
      end
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes and framing-bit errors.
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word({2'b01, make_char(8'hA5, 1'b1, 1'b0), make_char(8'hFF, 1'b1, 1'b0),
                 make_char(8'h00, 1'b1, 1'b0)}, 1'b1);
      // Both bits bad reports a bad start; then a bad start alone and a bad stop alone.
      send_word({2'b10, make_char(8'h3C, 1'b1, 1'b1), make_char(8'h5A, 1'b0, 1'b0),
                 make_char(8'h00, 1'b0, 1'b1)}, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b0);
      // Frame start while bits are carried.
      send_word({2'b11, make_char(8'h81, 1'b1, 1'b0), make_char(8'h7E, 1'b1, 1'b0),
                 make_char(8'hC3, 1'b1, 1'b0)}, 1'b1);
      // Thirteen characters take the carry up to eight bits, so four come from one word.
      send_frame(13, 0, 1'b1);

      // Random: mostly well-formed frames, some noise words.
      while (items_sent < RandomWords + 13) begin
         quiet = ($urandom_range(0, 5) == 0);
         if (!paused && items_sent >= 120) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 20) begin
            send_word($urandom, ($urandom_range(0, 99) < 30));
         end else begin
            send_frame($urandom_range(1, 12), 8, ($urandom_range(0, 9) != 0));
         end
      end
      quiet = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hw/rtl/ncd_pkg.sv
hw/rtl/ncd_char_decode.sv
hw/rtl/nrzl_character_deframer.sv
tb/tb_nrzl_character_deframer.sv
